@@ rtl/core/overtemp_valve_and_buzzer_alarm_defines.svh @@
// Assertion macros for the over-temperature alarm block.
// Define ASSERT_OFF to compile the assertions out.
`ifndef OVERTEMP_VALVE_AND_BUZZER_ALARM_DEFINES_SVH
`define OVERTEMP_VALVE_AND_BUZZER_ALARM_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset.
`define OVT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define OVT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OVT_ASSERT(label, clk, rst, prop, msg)
`define OVT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/core/ovt_pkg.sv @@
package ovt_pkg;

  localparam int TEMP_W      = 12;
  localparam int MARGIN_W    = 11;
  localparam int MS_W        = 16;
  localparam int THRESH_W    = TEMP_W + 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MS_W-1:0] ELAPSED_MAX = {MS_W{1'b1}};

  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST    = 12'sd1600;
  localparam logic [MARGIN_W-1:0]      TEMP_MARGIN_RST   = 11'd16;
  localparam logic                     ALARM_ENABLE_RST  = 1'b1;
  localparam logic [MS_W-1:0]          BUZZER_ON_MS_RST  = 16'd2000;
  localparam logic [MS_W-1:0]          BUZZER_OFF_MS_RST = 16'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEMP_LIMIT    = 3'd0,
    REG_TEMP_MARGIN   = 3'd1,
    REG_ALARM_ENABLE  = 3'd2,
    REG_BUZZER_ON_MS  = 3'd3,
    REG_BUZZER_OFF_MS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_limit;
    logic [MARGIN_W-1:0]      temp_margin;
    logic                     alarm_enable;
    logic [MS_W-1:0]          buzzer_on_ms;
    logic [MS_W-1:0]          buzzer_off_ms;
  } ovt_cfg_t;

  typedef struct packed {
    logic            valve_closed;
    logic            cycle_active;
    logic            buzzer_level;
    logic [MS_W-1:0] elapsed;
  } ovt_state_t;

  typedef struct packed {
    logic closed_event;
    logic opened_event;
  } ovt_events_t;

endpackage

@@ rtl/core/ovt_step.sv @@
module ovt_step (
  input  ovt_pkg::ovt_cfg_t                   cfg,
  input  ovt_pkg::ovt_state_t                 state,
  input  logic signed [ovt_pkg::TEMP_W-1:0]   temperature,
  input  logic                                process_running,
  input  logic                                sensor_fault,
  output ovt_pkg::ovt_state_t                 state_next,
  output ovt_pkg::ovt_events_t                events
);
  import ovt_pkg::*;

  logic signed [THRESH_W-1:0] temp_ext;
  logic signed [THRESH_W-1:0] limit_ext;
  logic signed [THRESH_W-1:0] threshold;
  logic [MS_W-1:0]            elapsed_step;
  logic [MS_W-1:0]            phase_len;
  ovt_state_t                 mid;

  assign temp_ext  = {{2{temperature[TEMP_W-1]}}, temperature};
  assign limit_ext = {{2{cfg.temp_limit[TEMP_W-1]}}, cfg.temp_limit};
  assign threshold = limit_ext + $signed({{(THRESH_W-MARGIN_W){1'b0}}, cfg.temp_margin});

  // The elapsed count moves first and saturates at its maximum.
  assign elapsed_step = (state.cycle_active && state.elapsed != ELAPSED_MAX)
                        ? state.elapsed + 1'b1 : state.elapsed;

  always_comb begin
    mid                 = state;
    mid.elapsed         = elapsed_step;
    events.closed_event = 1'b0;
    events.opened_event = 1'b0;

    // Closing is tested before opening, so a zero margin closes the valve.
    priority if (!process_running || sensor_fault) begin
      mid.cycle_active = 1'b0;
      mid.buzzer_level = 1'b0;
    end else if (temp_ext >= threshold) begin
      if (!state.valve_closed) begin
        mid.valve_closed    = 1'b1;
        events.closed_event = 1'b1;
      end
      if (cfg.alarm_enable && !state.cycle_active) begin
        mid.cycle_active = 1'b1;
        mid.buzzer_level = 1'b0;
        mid.elapsed      = '0;
      end
    end else if (temp_ext <= limit_ext) begin
      if (state.valve_closed) begin
        mid.valve_closed    = 1'b0;
        events.opened_event = 1'b1;
      end
      mid.cycle_active = 1'b0;
      mid.buzzer_level = 1'b0;
    end else begin
      // Inside the hysteresis band the valve and the cycle keep their state.
    end
  end

  assign phase_len = mid.buzzer_level ? cfg.buzzer_on_ms : cfg.buzzer_off_ms;

  always_comb begin
    state_next = mid;
    if (mid.cycle_active && mid.elapsed >= phase_len) begin
      state_next.buzzer_level = !mid.buzzer_level;
      state_next.elapsed      = '0;
    end
  end

endmodule

@@ rtl/core/overtemp_valve_and_buzzer_alarm.sv @@
// Over-temperature valve and buzzer alarm.
// Each input transaction is one millisecond tick: a signed temperature in
// 1/16 degree C plus the process-running and sensor-fault flags. Every input
// transaction yields exactly one output transaction with the valve level,
// the buzzer level, the cycling flag and one-tick valve change events.
// The result is registered: a tick accepted at one edge is offered on the
// output in the next cycle. One tick is taken per cycle while in_stall is
// low; the result register is the only storage in the path, so in_stall
// rises only while it holds a result that the receiver is stalling. The
// configuration port writes one register per cycle through cfg_write,
// cfg_index and cfg_data; the user must write only while no tick is in
// flight, which the block does not enforce. Reset is synchronous: it empties
// the result register, opens the valve, stops the buzzer cycle and loads the
// default limits and timings. While a result is offered and out_stall is
// high, that result holds still and no further tick is taken in.
`include "overtemp_valve_and_buzzer_alarm_defines.svh"

module overtemp_valve_and_buzzer_alarm (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [ovt_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ovt_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ovt_pkg::TEMP_W-1:0]     temperature,
  input  logic                                  process_running,
  input  logic                                  sensor_fault,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  valve_closed,
  output logic                                  buzzer_drive,
  output logic                                  alarm_cycling,
  output logic                                  closed_event,
  output logic                                  opened_event
);
  import ovt_pkg::*;

  ovt_cfg_t    cfg;
  ovt_state_t  state;
  ovt_state_t  state_next;
  ovt_events_t events;
  logic        out_ready;
  logic        in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_limit    <= TEMP_LIMIT_RST;
      cfg.temp_margin   <= TEMP_MARGIN_RST;
      cfg.alarm_enable  <= ALARM_ENABLE_RST;
      cfg.buzzer_on_ms  <= BUZZER_ON_MS_RST;
      cfg.buzzer_off_ms <= BUZZER_OFF_MS_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEMP_LIMIT:    cfg.temp_limit    <= $signed(cfg_data[TEMP_W-1:0]);
        REG_TEMP_MARGIN:   cfg.temp_margin   <= cfg_data[MARGIN_W-1:0];
        REG_ALARM_ENABLE:  cfg.alarm_enable  <= cfg_data[0];
        REG_BUZZER_ON_MS:  cfg.buzzer_on_ms  <= cfg_data[MS_W-1:0];
        REG_BUZZER_OFF_MS: cfg.buzzer_off_ms <= cfg_data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The result register frees up in the same cycle that its contents leave.
  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = !out_ready;
  assign in_fire   = in_valid && out_ready;

  ovt_step u_step (
    .cfg             (cfg),
    .state           (state),
    .temperature     (temperature),
    .process_running (process_running),
    .sensor_fault    (sensor_fault),
    .state_next      (state_next),
    .events          (events)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      valve_closed  <= state_next.valve_closed;
      buzzer_drive  <= state_next.buzzer_level;
      alarm_cycling <= state_next.cycle_active;
      closed_event  <= events.closed_event;
      opened_event  <= events.opened_event;
    end
  end

  `OVT_ASSERT(a_events_exclusive, clk, rst,
              out_valid |-> !(closed_event && opened_event),
              "open and close events in one transaction")
  `OVT_ASSERT(a_buzzer_needs_cycle, clk, rst,
              (out_valid && buzzer_drive) |-> alarm_cycling,
              "buzzer sounding outside an active cycle")
  `OVT_ASSERT(a_event_matches_valve, clk, rst,
              out_valid |-> ((!closed_event || valve_closed) &&
                             (!opened_event || !valve_closed)),
              "valve event disagrees with valve level")
  `OVT_ASSERT_ALWAYS(a_reset_empties, clk, $past(rst) |-> !out_valid,
                     "result offered right after reset")
  `OVT_ASSERT(a_state_follows_output, clk, rst,
              out_valid |-> (state.valve_closed == valve_closed &&
                             state.cycle_active == alarm_cycling),
              "state register out of step with result register")

endmodule

@@ test/overtemp_valve_and_buzzer_alarm_tb.sv @@
`timescale 1ns / 100ps

package ovt_alarm_tb_pkg;
  import ovt_pkg::*;

  typedef struct packed {
    logic valve_closed;
    logic buzzer_drive;
    logic alarm_cycling;
    logic closed_event;
    logic opened_event;
  } alarm_out_t;

  // Tracks the valve and buzzer state tick by tick and keeps the outputs
  // that are still owed by the block.
  class valve_alarm_tracker;
    ovt_cfg_t     cfg;
    bit           valve;
    bit           cycling;
    bit           level;
    int unsigned  elapsed;
    alarm_out_t   pending_outputs[$];
    int           checked;
    int           mismatches;
    int           closes;
    int           sounding_ticks;

    function new();
      cfg.temp_limit    = TEMP_LIMIT_RST;
      cfg.temp_margin   = TEMP_MARGIN_RST;
      cfg.alarm_enable  = ALARM_ENABLE_RST;
      cfg.buzzer_on_ms  = BUZZER_ON_MS_RST;
      cfg.buzzer_off_ms = BUZZER_OFF_MS_RST;
      valve          = 1'b0;
      cycling        = 1'b0;
      level          = 1'b0;
      elapsed        = 0;
      checked        = 0;
      mismatches     = 0;
      closes         = 0;
      sounding_ticks = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TEMP_LIMIT:    cfg.temp_limit    = data[TEMP_W-1:0];
        REG_TEMP_MARGIN:   cfg.temp_margin   = data[MARGIN_W-1:0];
        REG_ALARM_ENABLE:  cfg.alarm_enable  = data[0];
        REG_BUZZER_ON_MS:  cfg.buzzer_on_ms  = data[MS_W-1:0];
        REG_BUZZER_OFF_MS: cfg.buzzer_off_ms = data[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_tick(logic signed [TEMP_W-1:0] temp, bit running, bit fault);
      alarm_out_t  res;
      int          tv;
      int          lim;
      int          thresh;
      int unsigned phase_len;
      tv  = temp;
      lim = $signed(cfg.temp_limit);
      res = '0;
      if (cycling && elapsed < 65535) elapsed++;
      if (!running || fault) begin
        cycling = 1'b0;
        level   = 1'b0;
      end else begin
        thresh = lim + int'(cfg.temp_margin);
        if (tv >= thresh) begin
          if (!valve) begin
            valve = 1'b1;
            res.closed_event = 1'b1;
          end
          if (cfg.alarm_enable && !cycling) begin
            cycling = 1'b1;
            level   = 1'b0;
            elapsed = 0;
          end
        end else if (tv <= lim) begin
          if (valve) begin
            valve = 1'b0;
            res.opened_event = 1'b1;
          end
          cycling = 1'b0;
          level   = 1'b0;
        end
      end
      if (cycling) begin
        phase_len = level ? cfg.buzzer_on_ms : cfg.buzzer_off_ms;
        if (elapsed >= phase_len) begin
          level   = ~level;
          elapsed = 0;
        end
      end
      res.valve_closed  = valve;
      res.buzzer_drive  = level;
      res.alarm_cycling = cycling;
      if (res.closed_event) closes++;
      if (level) sounding_ticks++;
      pending_outputs.push_back(res);
    endfunction

    function void compare_output(alarm_out_t got);
      alarm_out_t want;
      int         bad;
      if (pending_outputs.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: output transaction with nothing expected: %b", $realtime, got);
        mismatches++;
        return;
      end
      want = pending_outputs.pop_front();
      checked++;
      bad = 0;
      if (got.valve_closed  !== want.valve_closed)  bad++;
      if (got.buzzer_drive  !== want.buzzer_drive)  bad++;
      if (got.alarm_cycling !== want.alarm_cycling) bad++;
      if (got.closed_event  !== want.closed_event)  bad++;
      if (got.opened_event  !== want.opened_event)  bad++;
      if (bad != 0) begin
        if (mismatches < 10)
          $display("%0t: output %0d mismatch (valve buzzer cycling closed opened)",
                   $realtime, checked, " expected %b %b %b %b %b, got %b %b %b %b %b",
                   want.valve_closed, want.buzzer_drive, want.alarm_cycling,
                   want.closed_event, want.opened_event,
                   got.valve_closed, got.buzzer_drive, got.alarm_cycling,
                   got.closed_event, got.opened_event);
        mismatches++;
      end
    endfunction

    function void flush_leftovers();
      if (pending_outputs.size() != 0) begin
        $display("%0d expected outputs never arrived", pending_outputs.size());
        mismatches += pending_outputs.size();
        pending_outputs.delete();
      end
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass
endpackage

module overtemp_valve_and_buzzer_alarm_tb;
  import ovt_pkg::*;
  import ovt_alarm_tb_pkg::*;

  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_TICKS    = 85;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] temperature;
  logic                     process_running;
  logic                     sensor_fault;
  logic                     out_valid;
  logic                     out_stall;
  logic                     valve_closed;
  logic                     buzzer_drive;
  logic                     alarm_cycling;
  logic                     closed_event;
  logic                     opened_event;

  valve_alarm_tracker tracker;
  bit                 idle_on;
  bit                 hold_off_req;
  int                 ticks_sent;
  int                 settings_used;
  int                 quiet_cycles;

  overtemp_valve_and_buzzer_alarm dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .temperature     (temperature),
    .process_running (process_running),
    .sensor_fault    (sensor_fault),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .valve_closed    (valve_closed),
    .buzzer_drive    (buzzer_drive),
    .alarm_cycling   (alarm_cycling),
    .closed_event    (closed_event),
    .opened_event    (opened_event)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_pause();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ovt_cfg_t pick_config(int phase);
    ovt_cfg_t c;
    case (phase)
      0: c = '{temp_limit: -12'sd2048, temp_margin: 11'd0, alarm_enable: 1'b1,
               buzzer_on_ms: 16'd0, buzzer_off_ms: 16'd0};
      1: c = '{temp_limit: 12'sd2047, temp_margin: 11'd2047, alarm_enable: 1'b1,
               buzzer_on_ms: 16'hFFFF, buzzer_off_ms: 16'hFFFF};
      2: c = '{temp_limit: 12'sd1600, temp_margin: 11'd16, alarm_enable: 1'b1,
               buzzer_on_ms: 16'd3, buzzer_off_ms: 16'd2};
      3: c = '{temp_limit: -12'sd880, temp_margin: 11'd2000, alarm_enable: 1'b1,
               buzzer_on_ms: 16'd1, buzzer_off_ms: 16'd1};
      4: c = '{temp_limit: 12'sd2000, temp_margin: 11'd0, alarm_enable: 1'b0,
               buzzer_on_ms: 16'd2, buzzer_off_ms: 16'd5};
      default: begin
        c.temp_limit   = 12'($urandom);
        c.temp_margin  = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                       : 11'($urandom_range(0, 40));
        c.alarm_enable = ($urandom_range(0, 3) != 0);
        c.buzzer_on_ms  = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 7));
        c.buzzer_off_ms = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 7));
      end
    endcase
    return c;
  endfunction

  // Temperatures cluster around the hysteresis band so that the valve moves often.
  function automatic logic signed [TEMP_W-1:0] pick_temp(ovt_cfg_t c);
    int lim;
    int span;
    int t;
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    lim  = $signed(c.temp_limit);
    span = int'(c.temp_margin) + 4;
    t    = int'($urandom_range(0, 2 * span)) - span + lim;
    if (t > 2047) t = 2047;
    if (t < -2048) t = -2048;
    return 12'(t);
  endfunction

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_config(ovt_cfg_t c);
    put_reg(REG_TEMP_LIMIT, {{(CFG_DATA_W - TEMP_W){c.temp_limit[TEMP_W-1]}}, c.temp_limit});
    put_reg(REG_TEMP_MARGIN, {{(CFG_DATA_W - MARGIN_W){1'b0}}, c.temp_margin});
    put_reg(REG_ALARM_ENABLE, {{(CFG_DATA_W - 1){1'b0}}, c.alarm_enable});
    put_reg(REG_BUZZER_ON_MS, c.buzzer_on_ms);
    put_reg(REG_BUZZER_OFF_MS, c.buzzer_off_ms);
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic offer(logic signed [TEMP_W-1:0] t, bit run, bit flt);
    int gap;
    in_valid        <= 1'b1;
    temperature     <= t;
    process_running <= run;
    sensor_fault    <= flt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_tick(t, run, flt);
    ticks_sent++;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The sender stops and waits until every owed output has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Receiver side: random stalls plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        repeat (1 + pick_pause()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.compare_output('{valve_closed: valve_closed, buzzer_drive: buzzer_drive,
                               alarm_cycling: alarm_cycling, closed_event: closed_event,
                               opened_event: opened_event});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ovt_cfg_t c;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_TEMP_LIMIT;
    cfg_data        = '0;
    in_valid        = 1'b0;
    temperature     = '0;
    process_running = 1'b0;
    sensor_fault    = 1'b0;
    idle_on         = 1'b1;
    hold_off_req    = 1'b0;
    ticks_sent      = 0;
    settings_used   = 1;
    quiet_cycles    = 0;
    tracker         = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: band edges, stopped process and sensor fault.
    offer(12'sd1615, 1, 0);
    offer(12'sd1616, 1, 0);
    offer(12'sd1601, 1, 0);
    offer(12'sd2047, 1, 0);
    offer(12'sd1600, 1, 0);
    offer(12'sd2047, 0, 0);
    offer(12'sd2000, 1, 0);
    offer(12'sd2047, 0, 0);
    offer(12'sd2047, 1, 1);
    offer(-12'sd2048, 1, 1);
    offer(-12'sd2048, 1, 0);
    offer(-12'sd880, 1, 0);

    // With no margin the closing test wins; zero times toggle on the start tick.
    drain();
    load_config('{temp_limit: 12'sd0, temp_margin: 11'd0, alarm_enable: 1'b1,
                  buzzer_on_ms: 16'd0, buzzer_off_ms: 16'd0});
    offer(12'sd0, 1, 0);
    offer(12'sd0, 1, 0);
    offer(12'sd0, 1, 0);
    offer(-12'sd1, 1, 0);
    offer(12'sd0, 0, 1);

    // Alarms disabled: the valve still closes but no buzzer cycle starts.
    drain();
    load_config('{temp_limit: -12'sd2048, temp_margin: 11'd2047, alarm_enable: 1'b0,
                  buzzer_on_ms: 16'hFFFF, buzzer_off_ms: 16'd1});
    offer(-12'sd1, 1, 0);
    offer(-12'sd2048, 1, 0);
    offer(-12'sd2, 1, 0);
    offer(12'sd2047, 1, 0);

    // Long off time: the counter runs for hundreds of ticks before the first tone.
    drain();
    idle_on = 1'b0;
    load_config('{temp_limit: 12'sd0, temp_margin: 11'd0, alarm_enable: 1'b1,
                  buzzer_on_ms: 16'd1, buzzer_off_ms: 16'd200});
    repeat (210) offer(12'sd100, 1, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      c       = pick_config(p);
      idle_on = (p % 4 != 2);
      load_config(c);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (p == 3 && i == 20) hold_off_req = 1'b1;
        offer(pick_temp(c), $urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    tracker.flush_leftovers();
    $display("Covered %0d ticks under %0d register settings, %0d outputs compared.",
             ticks_sent, settings_used, tracker.checked);
    $display("Valve closed %0d times; buzzer sounded on %0d ticks; %0d failures.",
             tracker.closes, tracker.sounding_ticks, tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
